/* sv/button_click_hold_event_scanner_top_macros.svh */
// ----------------------------------------------------------------------------
// Button scanner assertion macros
// Shared property forms for the scanner checkers.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_EVENT_SCANNER_TOP_MACROS_SVH
`define BUTTON_CLICK_HOLD_EVENT_SCANNER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define BCHE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BCHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always on
`define BCHE_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bche_pkg.sv */
// ----------------------------------------------------------------------------
// Button scanner package
// Event codes, register indexes and the per-button state word.
// ----------------------------------------------------------------------------
package bche_pkg;

    localparam int unsigned CNT_W = 16;
    localparam int unsigned EV_W  = 3;
    localparam int unsigned IDX_W = 3;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned MASK_W = 8;

    localparam logic [EV_W-1:0] EV_NONE        = 3'd0;
    localparam logic [EV_W-1:0] EV_CLICK_DOWN  = 3'd1;
    localparam logic [EV_W-1:0] EV_HOLD        = 3'd2;
    localparam logic [EV_W-1:0] EV_HOLD_REPEAT = 3'd3;
    localparam logic [EV_W-1:0] EV_CLICK_UP    = 3'd4;
    localparam logic [EV_W-1:0] EV_HOLD_UP     = 3'd5;

    localparam logic [1:0] REG_PRESS_MASK    = 2'd0;
    localparam logic [1:0] REG_DOWN_COUNT    = 2'd1;
    localparam logic [1:0] REG_HOLD_COUNT    = 2'd2;
    localparam logic [1:0] REG_REPEAT_PERIOD = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [CNT_W-1:0] press_count;
        logic [EV_W-1:0]  last_event;
        logic [CNT_W-1:0] repeat_phase;
    } t_state;

endpackage

/* sv/button_click_hold_event_scanner_top.sv */
// ----------------------------------------------------------------------------
// Button click / hold event scanner
// Per-button press counter in a state memory; reports click, hold, repeat
// and release events, one result beat per sample beat.
// ----------------------------------------------------------------------------
// channel | direction | handshake                     | payload
// in      | input     | i_in_valid / o_in_ready       | i_button_index, i_pin_level
// out     | output    | o_out_valid / i_out_ready     | o_button_id, o_event_kind,
//         |           |                               | o_out_notify
// cfg     | input     | i_cfg_wr_en                   | i_cfg_index, i_cfg_wdata
//
// One beat per cycle when the output is not held; outputs are registered.
// The state memory read is registered; the update stage then does the update
// and write-back, forwarding the new word to a sample of that button.
// Reset loads config defaults and clears control and per-entry valid flags.
// A held output stalls the update stage and then the input.
// ----------------------------------------------------------------------------
module button_click_hold_event_scanner_top
    import bche_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [IDX_W-1:0] i_button_index,
    input  logic             i_pin_level,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_button_id,
    output logic [EV_W-1:0]  o_event_kind,
    output logic             o_out_notify,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // configuration
    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0]  r_down;
    logic [CNT_W-1:0]  r_hold;
    logic [CNT_W-1:0]  r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_down   <= 16'd5;
            r_hold   <= 16'd100;
            r_period <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PRESS_MASK:    r_mask   <= i_cfg_wdata[MASK_W-1:0];
                REG_DOWN_COUNT:    r_down   <= i_cfg_wdata;
                REG_HOLD_COUNT:    r_hold   <= i_cfg_wdata;
                REG_REPEAT_PERIOD: r_period <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // state memory and per-entry valid flags
    t_state                 mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_vld;

    // update stage
    logic             r_s1_valid;
    logic [IDX_W-1:0] r_s1_idx;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_in_range;
    logic             r_s1_level;
    t_state           r_rd_data;
    logic             r_rd_vld;
    t_state           r_fwd_data;
    logic             r_fwd_hit;

    // output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_id;
    logic [EV_W-1:0]  r_out_kind;
    logic             r_out_notify;

    logic             s1_adv;
    logic             in_acc;
    logic             in_range;
    logic [AW+IDX_W-1:0] idx_wide;
    logic [AW-1:0]    rd_addr;
    logic             fwd_hit;
    logic             wr_en;

    t_state           cur;
    t_state           st_n;
    logic             pressed;
    logic [CNT_W-1:0] cnt_inc;
    logic             cnt_adv;
    logic [CNT_W:0]   ph_inc;
    logic [CNT_W-1:0] ph_n;
    logic [EV_W-1:0]  ev;
    logic             note;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_range = (32'(i_button_index) < NUM_BUTTONS);
    assign idx_wide = {{AW{1'b0}}, i_button_index};
    assign rd_addr  = in_range ? idx_wide[AW-1:0] : '0;
    assign wr_en    = s1_adv && r_s1_in_range;
    assign fwd_hit  = wr_en && (r_s1_idx == i_button_index);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_s1_addr] <= st_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_s1_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx      <= i_button_index;
            r_s1_addr     <= rd_addr;
            r_s1_in_range <= in_range;
            r_s1_level    <= i_pin_level;
            r_rd_vld      <= r_vld[rd_addr];
            r_fwd_hit     <= fwd_hit;
            r_fwd_data    <= st_n;
        end
    end

    // read-modify-write of one button's state
    always_comb begin
        cur = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
        pressed = (r_s1_level == r_mask[r_s1_idx]);
        cnt_adv = (cur.press_count != CNT_MAX);
        cnt_inc = cur.press_count + CNT_W'(cnt_adv);
        ph_inc  = {1'b0, cur.repeat_phase} + 17'd1;
        ph_n    = (ph_inc >= {1'b0, r_period}) ? '0 : ph_inc[CNT_W-1:0];
        ev      = EV_NONE;
        note    = 1'b0;
        st_n    = cur;
        if (pressed) begin
            st_n.press_count  = cnt_inc;
            st_n.repeat_phase = ph_n;
            if (cnt_adv && cnt_inc == r_down) begin
                ev   = EV_CLICK_DOWN;
                note = 1'b1;
            end else if (cnt_adv && cnt_inc == r_hold) begin
                ev   = EV_HOLD;
                note = 1'b1;
            end else if (cnt_inc >= r_hold) begin
                ev   = EV_HOLD_REPEAT;
                note = (r_period != '0) && (ph_n == '0);
            end
        end else begin
            st_n.press_count  = '0;
            st_n.repeat_phase = '0;
            if (cur.press_count != '0) begin
                if (cur.press_count >= r_down && cur.press_count < r_hold) begin
                    ev   = EV_CLICK_UP;
                    note = 1'b1;
                end else if (cur.press_count >= r_hold) begin
                    ev   = EV_HOLD_UP;
                    note = 1'b1;
                end
            end
        end
        if (ev != EV_NONE) begin
            st_n.last_event = ev;
        end
        if (!r_s1_in_range) begin
            ev   = EV_NONE;
            note = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_id     <= r_s1_idx;
            r_out_kind   <= ev;
            r_out_notify <= note;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_button_id  = r_out_id;
    assign o_event_kind = r_out_kind;
    assign o_out_notify = r_out_notify;

endmodule

/* sv/bche_checker.sv */
// ----------------------------------------------------------------------------
// Button scanner checker
// Port-level properties of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_click_hold_event_scanner_top_macros.svh"

module bche_checker
    import bche_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [IDX_W-1:0] o_button_id,
    input logic [EV_W-1:0]  o_event_kind,
    input logic             o_out_notify
);

    logic                   stall;
    logic [IDX_W+EV_W:0]    beat;
    logic                   none_kind;
    logic                   none_beat;
    logic                   edge_beat;
    logic                   far_beat;

    assign stall     = o_out_valid && !i_out_ready;
    assign beat      = {o_button_id, o_event_kind, o_out_notify};
    assign none_kind = (o_event_kind == EV_NONE);
    assign none_beat = o_out_valid && none_kind;
    assign edge_beat = o_out_valid && ((o_event_kind == EV_CLICK_DOWN) ||
                                       (o_event_kind == EV_HOLD) ||
                                       (o_event_kind == EV_CLICK_UP) ||
                                       (o_event_kind == EV_HOLD_UP));
    assign far_beat  = o_out_valid && (32'(o_button_id) >= NUM_BUTTONS);

    `BCHE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "output beat after reset")
    `BCHE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, o_out_valid && $stable(beat), "beat changed")
    `BCHE_ASSERT_NOW(a_none_quiet, i_clk, i_rst_n, none_beat, !o_out_notify, "notify without event")
    `BCHE_ASSERT_NOW(a_edge_notify, i_clk, i_rst_n, edge_beat, o_out_notify, "silent edge event")
    `BCHE_ASSERT_NOW(a_range_none, i_clk, i_rst_n, far_beat, none_kind, "event on absent button")

endmodule

bind button_click_hold_event_scanner_top bche_checker #(
    .NUM_BUTTONS(NUM_BUTTONS)
) u_bche_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_button_id  (o_button_id),
    .o_event_kind (o_event_kind),
    .o_out_notify (o_out_notify)
);
